// ===== design/q2aa_pkg.sv =====
// ----------------------------------------------------------------------------
// q2aa_pkg
// Constants shared by the quaternion to axis-angle converter: arctangent
// table, angle constants and fixed stage counts.
// ----------------------------------------------------------------------------
package q2aa_pkg;

  // Width of every result field
  localparam int OUT_W    = 16;
  // Root bits produced by the square root pipeline
  localparam int SQ_STEPS = 32;
  // Quotient bits produced by each divider lane
  localparam int QW       = 34;
  // Divider remainder width (root width plus one)
  localparam int RW       = SQ_STEPS + 1;
  // CORDIC datapath width and angle accumulator width
  localparam int CW       = 64;
  localparam int AW       = 34;
  // Extra fraction bits on the CORDIC operands (Q30 to Q58)
  localparam int GUARD    = 28;

  localparam longint PI_Q30      = 64'd3373259426;
  localparam longint HALF_PI_Q30 = 64'd1686629713;

  // atan(2^-i) in Q1.30
  localparam logic [30:0] ATAN_Q30 [32] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159,
    31'd67021687,  31'd33543516,  31'd16775851,  31'd8388437,
    31'd4194283,   31'd2097149,   31'd1048576,   31'd524288,
    31'd262144,    31'd131072,    31'd65536,     31'd32768,
    31'd16384,     31'd8192,      31'd4096,      31'd2048,
    31'd1024,      31'd512,       31'd256,       31'd128,
    31'd64,        31'd32,        31'd16,        31'd8,
    31'd4,         31'd2,         31'd1,         31'd0
  };

endpackage

// ===== design/quaternion_to_axis_angle.sv =====
// ----------------------------------------------------------------------------
// quaternion_to_axis_angle
// Converts a Q1.15 quaternion to a unit rotation axis and a Q3.13 angle
// using pipelined square roots, a pipelined CORDIC and pipelined dividers.
// ----------------------------------------------------------------------------
//
//  channel | signals                                    | dir | transfer when
//  --------+--------------------------------------------+-----+------------------
//  in      | in_valid, in_stall, quat_w/x/y/z           | in  | valid & !stall
//  out     | out_valid, out_stall, axis_x/y/z,          | out | valid & !stall
//          | angle_rad, zero_axis                       |     |
//
//  One quaternion enters per cycle while in_stall is low. The depth is set
//  by the 32-step square root pipeline followed by the 34-step divider
//  lanes, which run beside the CORDIC steps; with ITERATIONS above 34 the
//  CORDIC steps set that part of the depth instead.
//  rst is synchronous and clears only valid bits; payload registers are not
//  reset. A stalled output parks one result in a skid register; in_stall is
//  that register's full flag, so the whole pipeline freezes as a unit and
//  nothing is lost or repeated.
//
module quaternion_to_axis_angle #(
  parameter int DATA_WIDTH = 16,
  parameter int ITERATIONS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [DATA_WIDTH-1:0]         quat_w,
  input  logic signed [DATA_WIDTH-1:0]         quat_x,
  input  logic signed [DATA_WIDTH-1:0]         quat_y,
  input  logic signed [DATA_WIDTH-1:0]         quat_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [q2aa_pkg::OUT_W-1:0]    axis_x,
  output logic signed [q2aa_pkg::OUT_W-1:0]    axis_y,
  output logic signed [q2aa_pkg::OUT_W-1:0]    axis_z,
  output logic        [q2aa_pkg::OUT_W-1:0]    angle_rad,
  output logic                                 zero_axis
);
  import q2aa_pkg::*;

  localparam int D       = DATA_WIDTH;
  localparam int HS      = 31 - D;
  localparam int HSP     = (HS >= 0) ? HS : 0;
  localparam bit Q60_LEFT = (HS >= 0);
  // scale 2^(2D-2) to 2^60 (follows the original shift quirk for narrow D)
  localparam int Q60_SH  = (HS >= 0) ? 2 * (HS % 16) : 0;
  localparam int AS      = 33 - D;
  localparam int ANG_OW  = AW + 2;
  localparam longint MAXANG = (2 * PI_Q30 + (longint'(1) << (AS - 1))) >>> AS;
  localparam longint MAXPOS = (longint'(1) << (D - 1)) - 1;
  localparam int NW      = D + 31;
  localparam int P2      = (ITERATIONS > QW) ? ITERATIONS : QW;
  localparam logic [2*D-1:0] ONE = {2'b01, {(2*D-2){1'b0}}};

  typedef struct packed {
    logic [D-1:0]   w;
    logic [D-1:0]   x;
    logic [D-1:0]   y;
    logic [D-1:0]   z;
    logic [2*D-1:0] w2;
    logic [2*D-1:0] x2;
    logic [2*D-1:0] y2;
    logic [2*D-1:0] z2;
  } sq_t;

  typedef struct packed {
    logic [D-1:0]          w;
    logic [D-1:0]          x;
    logic [D-1:0]          y;
    logic [D-1:0]          z;
    logic                  zero;
    logic [63:0]           srem;
    logic [63:0]           mrem;
    logic [SQ_STEPS-1:0]   sroot;
    logic [SQ_STEPS-1:0]   mroot;
  } rt_t;

  typedef struct packed {
    logic [CW-1:0]            cx;
    logic [CW-1:0]            cy;
    logic [AW-1:0]            ang;
    logic                     zero;
    logic [2:0]               neg;
    logic [SQ_STEPS-1:0]      m;
    logic [2:0][NW-1:0]       n;
    logic [2:0][RW-1:0]       rem;
    logic [2:0][QW-1:0]       q;
  } p2_t;

  typedef struct packed {
    logic [OUT_W-1:0] ax;
    logic [OUT_W-1:0] ay;
    logic [OUT_W-1:0] az;
    logic [OUT_W-1:0] ang;
    logic             zero;
  } res_t;

  logic en;
  logic skid_valid;
  res_t skid;
  res_t res_out;
  res_t res_next;

  sq_t  sq;
  logic sq_v;
  rt_t  rt   [SQ_STEPS+1];
  logic rt_v [SQ_STEPS+1];
  p2_t  p2   [P2+1];
  logic p2_v [P2+1];

  // whole pipeline moves while the skid register is empty
  assign en       = !skid_valid;
  assign in_stall = skid_valid;

  // stage A: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      sq_v <= 1'b0;
    end else if (en) begin
      sq_v <= in_valid;
    end
    if (en) begin
      sq.w  <= quat_w;
      sq.x  <= quat_x;
      sq.y  <= quat_y;
      sq.z  <= quat_z;
      sq.w2 <= quat_w * quat_w;
      sq.x2 <= quat_x * quat_x;
      sq.y2 <= quat_y * quat_y;
      sq.z2 <= quat_z * quat_z;
    end
  end

  // stage B: radicands scaled to 2^60
  logic [2*D+1:0] sum_b;
  logic [2*D-1:0] srad_b;
  logic [63:0]    sq60_b;
  logic [63:0]    mq60_b;

  always_comb begin
    sum_b  = (2*D+2)'(sq.x2) + (2*D+2)'(sq.y2) + (2*D+2)'(sq.z2);
    srad_b = (sq.w2 >= ONE) ? '0 : ONE - sq.w2;
    if (Q60_LEFT) begin
      sq60_b = 64'(srad_b) << Q60_SH;
      mq60_b = 64'(sum_b) << Q60_SH;
    end else begin
      sq60_b = 64'(srad_b >> 2);
      mq60_b = 64'(sum_b >> 2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rt_v[0] <= 1'b0;
    end else if (en) begin
      rt_v[0] <= sq_v;
    end
    if (en) begin
      rt[0].w     <= sq.w;
      rt[0].x     <= sq.x;
      rt[0].y     <= sq.y;
      rt[0].z     <= sq.z;
      rt[0].zero  <= (sum_b == '0);
      rt[0].srem  <= sq60_b;
      rt[0].mrem  <= mq60_b;
      rt[0].sroot <= '0;
      rt[0].mroot <= '0;
    end
  end

  // square roots, one root bit per stage, both radicands in lockstep
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - j;
    rt_t        nx;
    logic [65:0] st;
    logic [65:0] mt;

    always_comb begin
      nx = rt[j];
      st = (66'(rt[j].sroot) << (B + 1)) + (66'(1) << (2 * B));
      mt = (66'(rt[j].mroot) << (B + 1)) + (66'(1) << (2 * B));
      if (66'(rt[j].srem) >= st) begin
        nx.srem  = rt[j].srem - st[63:0];
        nx.sroot = rt[j].sroot | (SQ_STEPS'(1) << B);
      end
      if (66'(rt[j].mrem) >= mt) begin
        nx.mrem  = rt[j].mrem - mt[63:0];
        nx.mroot = rt[j].mroot | (SQ_STEPS'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        rt_v[j+1] <= 1'b0;
      end else if (en) begin
        rt_v[j+1] <= rt_v[j];
      end
      if (en) begin
        rt[j+1] <= nx;
      end
    end
  end

  // CORDIC and divider setup
  p2_t                  init;
  logic signed [CW-1:0] w64;
  logic signed [CW-1:0] wq30;
  logic [SQ_STEPS-1:0]  m_i;
  logic [2:0][D-1:0]    comp;
  logic signed [D:0]    cs;
  logic [D-1:0]         mag;
  logic [NW-1:0]        num;

  always_comb begin
    init = '0;
    w64  = CW'($signed(rt[SQ_STEPS].w));
    wq30 = Q60_LEFT ? (w64 <<< HSP) : (w64 >>> 1);
    m_i  = (rt[SQ_STEPS].mroot == '0) ? SQ_STEPS'(1) : rt[SQ_STEPS].mroot;
    comp[0] = rt[SQ_STEPS].x;
    comp[1] = rt[SQ_STEPS].y;
    comp[2] = rt[SQ_STEPS].z;
    cs   = '0;
    mag  = '0;
    num  = '0;
    if (w64 < 0) begin
      init.cx  = CW'(rt[SQ_STEPS].sroot) << GUARD;
      init.cy  = (-wq30) <<< GUARD;
      init.ang = AW'(HALF_PI_Q30);
    end else begin
      init.cx  = wq30 <<< GUARD;
      init.cy  = CW'(rt[SQ_STEPS].sroot) << GUARD;
      init.ang = '0;
    end
    init.zero = rt[SQ_STEPS].zero;
    init.m    = m_i;
    for (int k = 0; k < 3; k++) begin
      cs          = (D+1)'($signed(comp[k]));
      init.neg[k] = cs[D];
      mag         = cs[D] ? D'(-cs) : D'(cs);
      num         = (NW'(mag) << 30) + NW'(m_i >> 1);
      init.n[k]   = num;
      init.rem[k] = RW'(num >> QW);
      init.q[k]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v[0] <= 1'b0;
    end else if (en) begin
      p2_v[0] <= rt_v[SQ_STEPS];
    end
    if (en) begin
      p2[0] <= init;
    end
  end

  // CORDIC vectoring steps and restoring division, one step per stage
  for (genvar i = 0; i < P2; i++) begin : g_step
    localparam int QB = QW - 1 - i;
    p2_t                  nx;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    logic [RW-1:0]        r2;

    always_comb begin
      nx = p2[i];
      xs = $signed(p2[i].cx) >>> i;
      ys = $signed(p2[i].cy) >>> i;
      r2 = '0;
      if (i < ITERATIONS) begin
        if ($signed(p2[i].cy) > 0) begin
          nx.cx  = p2[i].cx + ys;
          nx.cy  = p2[i].cy - xs;
          nx.ang = p2[i].ang + AW'(ATAN_Q30[i % 32]);
        end else begin
          nx.cx  = p2[i].cx - ys;
          nx.cy  = p2[i].cy + xs;
          nx.ang = p2[i].ang - AW'(ATAN_Q30[i % 32]);
        end
      end
      if (QB >= 0) begin
        for (int k = 0; k < 3; k++) begin
          r2 = {p2[i].rem[k][RW-2:0], p2[i].n[k][(QB >= 0) ? QB : 0]};
          if (r2 >= RW'(p2[i].m)) begin
            nx.rem[k] = r2 - RW'(p2[i].m);
            nx.q[k]   = p2[i].q[k] | (QW'(1) << ((QB >= 0) ? QB : 0));
          end else begin
            nx.rem[k] = r2;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        p2_v[i+1] <= 1'b0;
      end else if (en) begin
        p2_v[i+1] <= p2_v[i];
      end
      if (en) begin
        p2[i+1] <= nx;
      end
    end
  end

  // final rounding, clamping and saturation
  logic signed [AW-1:0]   ang_f;
  logic [ANG_OW-1:0]      ang_r;
  logic [QW-1:0]          qk;
  logic [2:0][OUT_W-1:0]  ax_f;

  always_comb begin
    ang_f = $signed(p2[P2].ang);
    if (ang_f < 0) begin
      ang_f = '0;
    end
    ang_r = ((ANG_OW'(ang_f) << 1) + ANG_OW'(longint'(1) << (AS - 1))) >> AS;
    if (ang_r > ANG_OW'(MAXANG)) begin
      ang_r = ANG_OW'(MAXANG);
    end
    qk = '0;
    for (int k = 0; k < 3; k++) begin
      qk = p2[P2].q[k];
      if (p2[P2].zero) begin
        ax_f[k] = '0;
      end else if (p2[P2].neg[k]) begin
        ax_f[k] = OUT_W'(-qk);
      end else if (qk > QW'(MAXPOS)) begin
        ax_f[k] = OUT_W'(MAXPOS);
      end else begin
        ax_f[k] = qk[OUT_W-1:0];
      end
    end
    res_next.ax   = ax_f[0];
    res_next.ay   = ax_f[1];
    res_next.az   = ax_f[2];
    res_next.ang  = ang_r[OUT_W-1:0];
    res_next.zero = p2[P2].zero;
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (!out_stall) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (!out_valid || !out_stall) begin
      out_valid <= p2_v[P2];
    end else if (p2_v[P2]) begin
      skid_valid <= 1'b1;
    end
    if (skid_valid) begin
      if (!out_stall) begin
        res_out <= skid;
      end
    end else if (!out_valid || !out_stall) begin
      res_out <= res_next;
    end else begin
      skid <= res_next;
    end
  end

  assign axis_x    = res_out.ax;
  assign axis_y    = res_out.ay;
  assign axis_z    = res_out.az;
  assign angle_rad = res_out.ang;
  assign zero_axis = res_out.zero;

  // skid only ever holds a second result behind a waiting one
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid full with empty output");

  a_skid_fill: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && out_stall))
    else $error("skid filled without a stalled output");

  a_zero_axis: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero_axis) |-> (axis_x == '0 && axis_y == '0 && axis_z == '0))
    else $error("zero axis flag with nonzero axis");

  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    (out_valid && D == 16) |-> (angle_rad <= OUT_W'(MAXANG)))
    else $error("angle above two pi");

endmodule
